// File: src/utf8_stream_decoder_unit_defines.svh
// Assertion macros shared by the decoder RTL.
`ifndef UTF8_STREAM_DECODER_UNIT_DEFINES_SVH
`define UTF8_STREAM_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define U8SD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define U8SD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/u8sd_pkg.sv
package u8sd_pkg;

  localparam int unsigned HELD_DEPTH = 4;

  localparam logic [20:0] REPL_CP    = 21'h3F;  // '?'
  localparam logic [7:0]  LEAD2_MASK = 8'hE0;
  localparam logic [7:0]  LEAD2_VAL  = 8'hC0;
  localparam logic [7:0]  LEAD3_MASK = 8'hF0;
  localparam logic [7:0]  LEAD3_VAL  = 8'hE0;
  localparam logic [7:0]  LEAD4_MASK = 8'hF8;
  localparam logic [7:0]  LEAD4_VAL  = 8'hF0;

  localparam logic [2:0]  LEN_ONE   = 3'd1;
  localparam logic [2:0]  LEN_TWO   = 3'd2;
  localparam logic [2:0]  LEN_THREE = 3'd3;
  localparam logic [2:0]  LEN_FOUR  = 3'd4;

  // One classified text byte.
  typedef struct packed {
    logic [7:0] text_byte;
    logic       eot;
    logic [2:0] len;   // window length if this byte leads
    logic       cont;  // 10xxxxxx
  } beat_t;

  // Back-end status for checks at the top.
  typedef struct packed {
    logic       busy;
    logic [2:0] held_cnt;
    logic       pop;
  } back_stat_t;

  function automatic logic [2:0] win_len(input logic [7:0] c);
    logic [2:0] len;
    len = LEN_ONE;
    if ((c & LEAD2_MASK) == LEAD2_VAL) len = LEN_TWO;
    else if ((c & LEAD3_MASK) == LEAD3_VAL) len = LEN_THREE;
    else if ((c & LEAD4_MASK) == LEAD4_VAL) len = LEN_FOUR;
    return len;
  endfunction

endpackage

// File: src/u8sd_if.sv
interface u8sd_in_if (input logic clk);
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, text_byte, end_of_text, input ready);
  modport sink   (input valid, text_byte, end_of_text, output ready);
endinterface

interface u8sd_out_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic        replaced;
  logic        last_of_run;

  modport source (output valid, code_point, replaced, last_of_run, input ready);
  modport sink   (input valid, code_point, replaced, last_of_run, output ready);
endinterface

// File: src/u8sd_front.sv
module u8sd_front
  import u8sd_pkg::*;
(
  u8sd_in_if.sink byte_stream,
  input  logic    push_ready,
  output logic    push_valid,
  output beat_t   push_data
);

  assign push_valid  = byte_stream.valid;
  assign byte_stream.ready = push_ready;

  always_comb begin
    push_data.text_byte = byte_stream.text_byte;
    push_data.eot       = byte_stream.end_of_text;
    push_data.len       = win_len(byte_stream.text_byte);
    push_data.cont      = (byte_stream.text_byte[7:6] == 2'b10);
  end

endmodule

// File: src/u8sd_queue.sv
module u8sd_queue
  import u8sd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  input  beat_t push_data,
  output logic  push_ready,
  output logic  pop_valid,
  output beat_t pop_data,
  input  logic  pop
);

  beat_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: src/u8sd_back.sv
module u8sd_back
  import u8sd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  beat_t      q_data,
  output logic       q_pop,
  u8sd_out_if.source code_stream,
  output back_stat_t stat
);

  beat_t       held [HELD_DEPTH];
  logic [2:0]  held_cnt;
  logic        busy;
  logic        eot_r;

  logic        out_valid;
  logic [20:0] out_cp;
  logic        out_repl;
  logic        out_last;

  beat_t       w  [HELD_DEPTH];
  beat_t       sh [HELD_DEPTH];
  logic [2:0]  wcnt;
  logic        weot;
  logic        have;
  logic        out_free;
  logic        advance;
  logic [2:0]  need;
  logic        ok;
  logic        emit;
  logic [20:0] res_cp;
  logic        res_repl;
  logic [2:0]  drop;
  logic [2:0]  rcnt;
  logic [2:0]  idx;
  logic        last;
  logic        busy_next;

  assign out_free = !out_valid || code_stream.ready;

  always_comb begin
    // working window: held bytes, plus the next queued byte when idle
    w     = held;
    wcnt  = held_cnt;
    weot  = eot_r;
    have  = busy;
    q_pop = 1'b0;
    if (!busy) begin
      have  = q_valid;
      q_pop = q_valid && out_free;
      if (q_valid) begin
        w[held_cnt[1:0]] = q_data;
        wcnt = held_cnt + 3'd1;
        weot = q_data.eot;
      end
    end
    advance = have && out_free;

    need = w[0].len;
    case (need)
      LEN_TWO:   ok = w[1].cont;
      LEN_THREE: ok = w[1].cont && w[2].cont;
      LEN_FOUR:  ok = w[1].cont && w[2].cont && w[3].cont;
      default:   ok = 1'b1;
    endcase

    emit     = 1'b1;
    res_cp   = REPL_CP;
    res_repl = 1'b1;
    drop     = 3'd1;
    if (wcnt < need) begin
      // incomplete window: wait, or give one '?' at end of text
      emit = weot;
      drop = weot ? wcnt : 3'd0;
    end else if (need == LEN_ONE) begin
      if (!w[0].text_byte[7]) begin
        res_cp   = {13'd0, w[0].text_byte};
        res_repl = 1'b0;
      end
    end else if (ok) begin
      res_repl = 1'b0;
      drop     = need;
      case (need)
        LEN_TWO:   res_cp = {10'd0, w[0].text_byte[4:0], w[1].text_byte[5:0]};
        LEN_THREE: res_cp = {5'd0, w[0].text_byte[3:0], w[1].text_byte[5:0],
                             w[2].text_byte[5:0]};
        default:   res_cp = {w[0].text_byte[2:0], w[1].text_byte[5:0],
                             w[2].text_byte[5:0], w[3].text_byte[5:0]};
      endcase
    end

    rcnt = wcnt - drop;
    for (int i = 0; i < HELD_DEPTH; i++) begin
      idx   = 3'(i) + drop;
      sh[i] = (idx < 3'(HELD_DEPTH)) ? w[idx[1:0]] : w[i];
    end

    // final result of this byte once nothing more can come out now
    last      = (rcnt == 3'd0) || ((rcnt < sh[0].len) && !weot);
    busy_next = emit && !last;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      held  <= sh;
      eot_r <= weot;
    end
    if (out_free && advance && emit) begin
      out_cp   <= res_cp;
      out_repl <= res_repl;
      out_last <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_cnt  <= 3'd0;
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        held_cnt <= rcnt;
        busy     <= busy_next;
      end
      if (out_free) out_valid <= advance && emit;
    end
  end

  assign code_stream.valid       = out_valid;
  assign code_stream.code_point  = out_cp;
  assign code_stream.replaced    = out_repl;
  assign code_stream.last_of_run = out_last;

  assign stat.busy     = busy;
  assign stat.held_cnt = held_cnt;
  assign stat.pop      = q_pop;

endmodule

// File: src/utf8_stream_decoder_unit.sv
// UTF-8 byte stream to code point decoder.
// byte_stream (sink): one text byte per beat, end_of_text on the final byte.
// code_stream (source): one code point per beat; replaced marks a '?' that
//   stands in for malformed bytes, last_of_run marks the final result caused
//   by one input byte. A byte that only extends an open window gives no beat.
// Path: front classifies each byte (window length, continuation) and pushes
//   it into a 2-entry queue; the back end appends it to a 4-byte hold window
//   and resolves one result per unstalled cycle into the output register.
// A byte is registered in the queue, then its result in the output register.
// Throughput: 1 byte per cycle for ASCII and well-formed sequences while the
//   receiver takes every beat. A byte that yields k results (k up to 4, e.g. a
//   broken window replay) holds the back end until all k results are out.
// Reset (rst, synchronous): queue emptied, hold window cleared, no result.
// Receiver stall: the output register holds its beat; the back end stops,
//   the queue fills, and byte_stream.ready drops once two bytes are waiting.
module utf8_stream_decoder_unit
  import u8sd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  u8sd_in_if.sink    byte_stream,
  u8sd_out_if.source code_stream
);

`include "utf8_stream_decoder_unit_defines.svh"

  logic       push_valid;
  logic       push_ready;
  beat_t      push_data;
  logic       q_valid;
  beat_t      q_data;
  logic       q_pop;
  back_stat_t stat;

  // classify incoming bytes
  u8sd_front u_front (
    .byte_stream (byte_stream),
    .push_ready  (push_ready),
    .push_valid  (push_valid),
    .push_data   (push_data)
  );

  // decouples the input handshake from the resolve loop
  u8sd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (q_valid),
    .pop_data   (q_data),
    .pop        (q_pop)
  );

  // window hold, decode, replay and output register
  u8sd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_data      (q_data),
    .q_pop       (q_pop),
    .code_stream (code_stream),
    .stat        (stat)
  );

  // while replaying, something must still be held
  `U8SD_ASSERT_NOW(a_busy_held, stat.busy, stat.held_cnt != 3'd0, "busy with empty window")
  // between steps at most three bytes wait for their window
  `U8SD_ASSERT_NOW(a_idle_cnt, !stat.busy, stat.held_cnt <= 3'd3, "hold window overflow")
  // a non-final result means the back end still owes more for that byte
  `U8SD_ASSERT_NOW(a_run_open, code_stream.valid && !code_stream.last_of_run,
                   stat.busy, "run ended without last_of_run")
  // never pop from an empty queue, never pop mid-replay
  `U8SD_ASSERT_NOW(a_pop_ok, stat.pop, q_valid && !stat.busy, "bad queue pop")

endmodule

// File: sim/utf8_decode_monitor.sv
`timescale 1ns / 100ps

// Watches both channels, predicts the code point beats from the accepted text
// bytes and checks the output beats against them in order.
module utf8_decode_monitor
  import u8sd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  u8sd_in_if          byte_mon,
  u8sd_out_if         code_mon,
  output int unsigned fail_count,
  output int unsigned pending
);

  localparam int unsigned REPORT_MAX = 10;

  typedef struct packed {
    logic [20:0] code_point;
    logic        replaced;
    logic        last_of_run;
  } code_beat_t;

  code_beat_t  expected_cps [$];
  logic [7:0]  held [HELD_DEPTH];
  int unsigned held_cnt = 0;
  int unsigned errors = 0;

  assign fail_count = errors;

  // Window length opened by a byte in lead position.
  function automatic int unsigned seq_len(input logic [7:0] c);
    if (c[7:5] == 3'b110) return 2;
    if (c[7:4] == 4'b1110) return 3;
    if (c[7:3] == 5'b11110) return 4;
    return 1;
  endfunction

  task automatic drop_held(input int unsigned n);
    int unsigned i;
    if (n >= held_cnt) begin
      held_cnt = 0;
    end else begin
      for (i = 0; i < held_cnt - n; i++) held[i] = held[i + n];
      held_cnt = held_cnt - n;
    end
  endtask

  task automatic note_failure(input string msg);
    errors++;
    if (errors <= REPORT_MAX) $display("%0t: %s", $realtime, msg);
  endtask

  // Append one byte to the hold window and resolve everything it completes.
  task automatic decode_byte(input logic [7:0] b, input logic eot);
    code_beat_t  run [HELD_DEPTH];
    int unsigned produced, need, j;
    logic [7:0]  lead;
    logic [20:0] cp;
    logic        good;
    produced = 0;
    if (held_cnt >= HELD_DEPTH) held_cnt = 0;
    held[held_cnt] = b;
    held_cnt++;
    while (held_cnt > 0 && produced < HELD_DEPTH) begin
      lead = held[0];
      need = seq_len(lead);
      if (held_cnt < need) begin
        // cut off by end of text: whole window collapses to one '?'
        if (eot) begin
          run[produced] = '{REPL_CP, 1'b1, 1'b0};
          produced++;
          held_cnt = 0;
        end
        break;
      end
      if (need == 1) begin
        if (!lead[7]) run[produced] = '{{13'd0, lead}, 1'b0, 1'b0};
        else run[produced] = '{REPL_CP, 1'b1, 1'b0};
        produced++;
        drop_held(1);
        continue;
      end
      case (need)
        2:       cp = {16'd0, lead[4:0]};
        3:       cp = {17'd0, lead[3:0]};
        default: cp = {18'd0, lead[2:0]};
      endcase
      good = 1'b1;
      for (j = 1; j < need; j++) begin
        if (held[j][7:6] != 2'b10) good = 1'b0;
        cp = {cp[14:0], held[j][5:0]};
      end
      if (good) begin
        run[produced] = '{cp, 1'b0, 1'b0};
        drop_held(need);
      end else begin
        // broken window: '?' for the lead, rest is replayed
        run[produced] = '{REPL_CP, 1'b1, 1'b0};
        drop_held(1);
      end
      produced++;
    end
    if (produced > 0) run[produced - 1].last_of_run = 1'b1;
    for (j = 0; j < produced; j++) expected_cps.push_back(run[j]);
  endtask

  always @(posedge clk) begin
    code_beat_t got, want;
    if (rst) begin
      held_cnt = 0;
      expected_cps.delete();
      pending <= 0;
    end else begin
      // outputs first: a byte taken at this edge cannot have a result yet
      if (code_mon.valid && code_mon.ready) begin
        got = '{code_mon.code_point, code_mon.replaced, code_mon.last_of_run};
        if (expected_cps.size() == 0) begin
          note_failure($sformatf("unexpected beat: cp=%h replaced=%b last=%b",
                                 got.code_point, got.replaced, got.last_of_run));
        end else begin
          want = expected_cps.pop_front();
          if (got.code_point !== want.code_point || got.replaced !== want.replaced ||
              got.last_of_run !== want.last_of_run)
            note_failure($sformatf(
              "mismatch: expected cp=%h replaced=%b last=%b, got cp=%h replaced=%b last=%b",
              want.code_point, want.replaced, want.last_of_run,
              got.code_point, got.replaced, got.last_of_run));
        end
      end
      if (byte_mon.valid && byte_mon.ready)
        decode_byte(byte_mon.text_byte, byte_mon.end_of_text);
      pending <= expected_cps.size();
    end
  end

endmodule

// File: sim/tb_utf8_stream_decoder_unit.sv
`timescale 1ns / 100ps

// Top of the decoder bench: clock, reset, byte stimulus, receiver backpressure,
// a no-progress watchdog and the final verdict. Prediction and comparison live
// in utf8_decode_monitor.
module tb_utf8_stream_decoder_unit;
  import u8sd_pkg::*;

  // Cycles without any accepted beat before the run is declared hung. The
  // longest honest quiet stretch is a run of random gaps on both sides.
  localparam int unsigned STALL_LIMIT = 2000;
  // Settle time after the last expected beat; covers the queue and output
  // registers plus a full 4-beat replay, to catch stray trailing beats.
  localparam int unsigned DRAIN_CYCLES = 12;

  logic        clk;
  logic        rst;
  int unsigned src_gap_pct;
  int unsigned sink_gap_pct;
  int unsigned idle_cycles;
  int unsigned fail_count;
  int unsigned pending;

  u8sd_in_if  byte_stream (clk);
  u8sd_out_if code_stream (clk);

  utf8_stream_decoder_unit dut (
    .clk         (clk),
    .rst         (rst),
    .byte_stream (byte_stream),
    .code_stream (code_stream)
  );

  utf8_decode_monitor decode_mon (
    .clk        (clk),
    .rst        (rst),
    .byte_mon   (byte_stream),
    .code_mon   (code_stream),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: ready is redrawn every cycle, low with sink_gap_pct percent.
  always @(posedge clk) begin
    if (rst) code_stream.ready <= 1'b0;
    else code_stream.ready <= ($urandom_range(99) >= sink_gap_pct);
  end

  // Watchdog: any accepted beat on either side counts as progress.
  always @(posedge clk) begin
    if (rst || (byte_stream.valid && byte_stream.ready) ||
        (code_stream.valid && code_stream.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Present one byte, with random gaps in front of it, and hold it until the
  // decoder takes it. Returns right after the accepting edge, so valid may be
  // kept high straight into the next beat without a low/high glitch.
  task automatic send_beat(input logic [7:0] b, input logic eot);
    while ($urandom_range(99) < src_gap_pct) begin
      byte_stream.valid <= 1'b0;
      @(posedge clk);
    end
    byte_stream.valid       <= 1'b1;
    byte_stream.text_byte   <= b;
    byte_stream.end_of_text <= eot;
    do @(posedge clk); while (!byte_stream.ready);
  endtask

  // Sender holds off until every predicted code point has come out.
  task automatic wait_drained();
    byte_stream.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Random texts: each is 1..8 characters, end_of_text on its final byte.
  // Most characters are well-formed sequences of random length and payload;
  // the rest are truncated sequences (broken windows, or cut off at the end
  // of the text) and raw random bytes (stray continuations, invalid leads).
  task automatic send_random_texts(input int unsigned n_bytes);
    logic [7:0]  seq [4];
    logic [31:0] r;
    int unsigned sent, chars, i, k, len, kind, seq_n;
    sent = 0;
    while (sent < n_bytes) begin
      chars = $urandom_range(1, 8);
      for (i = 0; i < chars; i++) begin
        r    = $urandom();
        len  = $urandom_range(1, 4);
        kind = $urandom_range(99);
        case (len)
          1:       seq[0] = {1'b0, r[6:0]};
          2:       seq[0] = {3'b110, r[4:0]};
          3:       seq[0] = {4'b1110, r[3:0]};
          default: seq[0] = {5'b11110, r[2:0]};
        endcase
        for (k = 1; k < 4; k++) seq[k] = {2'b10, 6'($urandom())};
        seq_n = len;
        if (kind >= 75 && kind < 88 && len > 1) begin
          seq_n = $urandom_range(1, len - 1);
        end else if (kind >= 88) begin
          seq_n = $urandom_range(1, 3);
          for (k = 0; k < seq_n; k++) seq[k] = 8'($urandom());
        end
        for (k = 0; k < seq_n; k++) begin
          send_beat(seq[k], (i == chars - 1) && (k == seq_n - 1));
          sent++;
        end
      end
    end
  endtask

  initial begin
    rst                     = 1'b1;
    byte_stream.valid       = 1'b0;
    byte_stream.text_byte   = 8'h00;
    byte_stream.end_of_text = 1'b0;
    src_gap_pct             = 16;
    sink_gap_pct            = 46;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // ASCII extremes
    send_beat(8'h00, 1'b0);
    send_beat(8'h7F, 1'b0);
    // two-byte range ends: U+0080, U+07FF
    send_beat(8'hC2, 1'b0); send_beat(8'h80, 1'b0);
    send_beat(8'hDF, 1'b0); send_beat(8'hBF, 1'b0);
    // three-byte top: U+FFFF
    send_beat(8'hEF, 1'b0); send_beat(8'hBF, 1'b0); send_beat(8'hBF, 1'b0);
    // unchecked lead 0xF7 with all-ones payload: widest code point
    send_beat(8'hF7, 1'b0); send_beat(8'hBF, 1'b0);
    send_beat(8'hBF, 1'b0); send_beat(8'hBF, 1'b0);
    // stray continuation and invalid leads
    send_beat(8'h80, 1'b0);
    send_beat(8'hF8, 1'b0);
    send_beat(8'hFF, 1'b0);
    // broken four-byte window: four results from one byte, text ends there
    send_beat(8'hF0, 1'b0); send_beat(8'h41, 1'b0);
    send_beat(8'h42, 1'b0); send_beat(8'h43, 1'b1);
    // broken window whose replay holds a stray continuation
    send_beat(8'hE1, 1'b0); send_beat(8'h80, 1'b0); send_beat(8'h41, 1'b0);
    // cut off by end of text, with an ASCII byte inside the window
    send_beat(8'hE2, 1'b0); send_beat(8'h41, 1'b1);
    // lone lead as the whole text
    send_beat(8'hC3, 1'b1);

    send_random_texts(130);
    wait_drained();

    src_gap_pct  = 46;
    sink_gap_pct = 16;
    send_random_texts(135);
    wait_drained();

    // full rate on both sides
    src_gap_pct  = 0;
    sink_gap_pct = 0;
    send_random_texts(135);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+src
src/u8sd_pkg.sv
src/u8sd_if.sv
src/u8sd_front.sv
src/u8sd_queue.sv
src/u8sd_back.sv
src/utf8_stream_decoder_unit.sv
sim/utf8_decode_monitor.sv
sim/tb_utf8_stream_decoder_unit.sv
